>>> src/random_pick_without_replacement_top_defines.svh
// Assertion macros for the random pick without replacement block.
`ifndef RANDOM_PICK_WITHOUT_REPLACEMENT_TOP_DEFINES_SVH
`define RANDOM_PICK_WITHOUT_REPLACEMENT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RPWR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RPWR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RPWR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RPWR_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> src/rpwr_pkg.sv
// Package: constants, register indexes and sequencer states for the pick block.
`default_nettype none
package rpwr_pkg;

  // configuration port
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 2'd1;

  // register reset values
  localparam logic [CFG_W-1:0] POOL_RESET = 7'd64;
  localparam logic [CFG_W-1:0] PICK_RESET = 7'd1;

  // parameter defaults
  localparam int DEF_MAX_POOL  = 64;
  localparam int DEF_RAND_BITS = 15;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FOLD,
    S_CORR,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> src/rpwr_in_if.sv
// Input channel: one random word per transfer.
`default_nettype none
interface rpwr_in_if #(
  parameter int RAND_BITS = 15
) ();
  logic                 valid;
  logic                 ready;
  logic [RAND_BITS-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface
`default_nettype wire

>>> src/rpwr_out_if.sv
// Output channel: one pick per transfer.
`default_nettype none
interface rpwr_out_if #(
  parameter int VAL_W = 6
) ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] picked_value;
  logic             last_pick;
  logic             error_flag;

  modport source (output valid, output picked_value, output last_pick, output error_flag,
                  input ready);
  modport sink   (input valid, input picked_value, input last_pick, input error_flag,
                  output ready);
endinterface
`default_nettype wire

>>> src/random_pick_without_replacement_top.sv
// Top level: draws elements without replacement from a configurable pool.
`default_nettype none
`include "random_pick_without_replacement_top_defines.svh"

// Each accepted random word yields one pick from the list of elements still
// held. The list index is floor(r * (remaining - 1) / (2^RAND_BITS - 1)):
// the multiply state forms the product, the fold state splits it at RAND_BITS,
// then the correction state checks the folded remainder. The remainder
// never reaches twice 2^RAND_BITS - 1, so at most one subtraction is needed,
// and it takes a second pass through the correction state. Then the shift
// state has the row of list cells drop the picked entry and shift the tail
// down, or refills the list after the last pick, and the done state loads
// the output register once it is empty or being read. The input is not ready
// until the result has moved into the output register and is ready in the
// cycle after that. With a zero effective pick count the accepted word goes
// straight to the done state, which loads the error word. Writing either
// register restarts the draw; the list refills with the write, so there is
// no clearing pass.
module random_pick_without_replacement_top
  import rpwr_pkg::*;
#(
  parameter int MAX_POOL  = DEF_MAX_POOL,
  parameter int RAND_BITS = DEF_RAND_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  rpwr_in_if.sink                   rand_in,
  rpwr_out_if.source                pick_out
);

  localparam int PW     = $clog2(MAX_POOL);
  localparam int CW     = $clog2(MAX_POOL + 1);
  localparam int PROD_W = RAND_BITS + PW;
  localparam int TW     = ((RAND_BITS > PW) ? RAND_BITS : PW) + 1;
  localparam longint RMAX_L = (64'd1 << RAND_BITS) - 64'd1;
  localparam logic [TW-1:0] RMAX = TW'(RMAX_L);
  localparam int POOL_RST_I = (int'(POOL_RESET) > MAX_POOL) ? MAX_POOL : int'(POOL_RESET);

  // configuration and draw state
  logic [CFG_W-1:0] pool_size, pool_size_next;
  logic [CFG_W-1:0] pick_count, pick_count_next;
  logic             cfg_hit;
  logic [CW-1:0]    p_eff;
  logic [CW-1:0]    cnt_eff;
  logic [CW-1:0]    rem;
  logic [CW-1:0]    picks_done;
  logic [PW-1:0]    list [MAX_POOL];

  // work registers of the shared unit
  state_t               state, state_next;
  logic [RAND_BITS-1:0] rnd;
  logic [PROD_W-1:0]    prod;
  logic [PW-1:0]        qacc;
  logic [TW-1:0]        tacc;
  logic [PW-1:0]        sel;
  logic [PW-1:0]        rem_m1;
  logic                 last;

  // result word and output register
  logic [PW-1:0] res_val;
  logic          res_last;
  logic          res_err;
  logic          ovalid;
  logic [PW-1:0] oval;
  logic          olast;
  logic          oerr;
  logic          acc;
  logic          load;

  // register writes and effective sizes
  always_comb begin
    cfg_hit = cfg_we && ((cfg_index == REG_POOL_SIZE) || (cfg_index == REG_PICK_COUNT));
    pool_size_next  = pool_size;
    pick_count_next = pick_count;
    if (cfg_we && (cfg_index == REG_POOL_SIZE)) begin
      pool_size_next = cfg_data;
    end
    if (cfg_we && (cfg_index == REG_PICK_COUNT)) begin
      pick_count_next = cfg_data;
    end
    if (pool_size_next == '0) begin
      p_eff = CW'(1);
    end else if (int'(pool_size_next) > MAX_POOL) begin
      p_eff = CW'(MAX_POOL);
    end else begin
      p_eff = CW'(pool_size_next);
    end
    if (int'(pick_count) >= int'(p_eff)) begin
      cnt_eff = p_eff - CW'(1);
    end else begin
      cnt_eff = CW'(pick_count);
    end
  end

  // pick select: each cell drives the bus when its place matches the index
  always_comb begin
    sel = '0;
    for (int i = 0; i < MAX_POOL; i++) begin
      sel = sel | (list[i] & {PW{PW'(i) == qacc}});
    end
  end

  assign rem_m1 = PW'(rem - CW'(1));
  assign last   = (picks_done + CW'(1)) >= cnt_eff;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next    = state;
    rand_in.ready = 1'b0;
    load          = 1'b0;
    case (state)
      S_IDLE: begin
        rand_in.ready = !rst;
        if (rand_in.valid) begin
          state_next = (cnt_eff == '0) ? S_DONE : S_MUL;
        end
      end
      S_MUL:   state_next = S_FOLD;
      S_FOLD:  state_next = S_CORR;
      S_CORR: begin
        if (tacc < RMAX) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: state_next = S_DONE;
      S_DONE: begin
        load = !ovalid || pick_out.ready;
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign acc = rand_in.valid && rand_in.ready;

  // datapath, list cells and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size  <= POOL_RESET;
      pick_count <= PICK_RESET;
      rem        <= CW'(POOL_RST_I);
      picks_done <= '0;
      ovalid     <= 1'b0;
      for (int k = 0; k < MAX_POOL; k++) begin
        list[k] <= PW'(k);
      end
    end else begin
      pool_size  <= pool_size_next;
      pick_count <= pick_count_next;
      if (cfg_hit) begin
        rem        <= p_eff;
        picks_done <= '0;
        for (int k = 0; k < MAX_POOL; k++) begin
          list[k] <= PW'(k);
        end
      end
      // a word taken while a new one loads keeps the register full
      if (pick_out.valid && pick_out.ready && !load) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            rnd      <= rand_in.random_word;
            res_val  <= '0;
            res_last <= 1'b0;
            res_err  <= (cnt_eff == '0);
          end
        end
        S_MUL: begin
          prod <= PROD_W'(rnd) * PROD_W'(rem_m1);
        end
        S_FOLD: begin
          // x = hi*2^B + lo = hi*(2^B-1) + (hi + lo)
          qacc <= prod[PROD_W-1:RAND_BITS];
          tacc <= TW'(prod[PROD_W-1:RAND_BITS]) + TW'(prod[RAND_BITS-1:0]);
        end
        S_CORR: begin
          if (tacc >= RMAX) begin
            tacc <= tacc - RMAX;
            qacc <= qacc + PW'(1);
          end
        end
        S_SHIFT: begin
          res_val  <= sel;
          res_last <= last;
          if (last) begin
            rem        <= p_eff;
            picks_done <= '0;
            for (int k = 0; k < MAX_POOL; k++) begin
              list[k] <= PW'(k);
            end
          end else begin
            rem        <= rem - CW'(1);
            picks_done <= picks_done + CW'(1);
            for (int i = 0; i < MAX_POOL - 1; i++) begin
              if ((PW'(i) >= qacc) && (CW'(i + 1) < rem)) begin
                list[i] <= list[i + 1];
              end
            end
          end
        end
        S_DONE: begin
          if (load) begin
            ovalid <= 1'b1;
            oval   <= res_val;
            olast  <= res_last;
            oerr   <= res_err;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign pick_out.valid        = ovalid;
  assign pick_out.picked_value = oval;
  assign pick_out.last_pick    = olast;
  assign pick_out.error_flag   = oerr;

  // checks
  `RPWR_ASSERT_IMP(a_rem_range, clk, rst, 1'b1,
    (rem != '0) && (rem <= CW'(MAX_POOL)), "remaining count out of range")
  `RPWR_ASSERT_IMP(a_idx_in_list, clk, rst, state == S_SHIFT,
    CW'(qacc) < rem, "pick index beyond remaining list")
  `RPWR_ASSERT_IMP(a_picks_bound, clk, rst, (state == S_IDLE) && !cfg_we,
    (picks_done < cnt_eff) || (picks_done == '0), "pick counter passed draw length")
  `RPWR_ASSERT_NXT(a_err_bypass, clk, rst, acc && (cnt_eff == '0),
    (state == S_DONE) && res_err, "zero pick count did not take error path")

endmodule
`default_nettype wire
